[rtl/core/gisc_pkg.sv]
// ============================================================================
// gisc_pkg
// Shared constants, cell codes and width helpers for the grid infection
// spread counter.
// ============================================================================
`default_nettype none

package gisc_pkg;

   // Default grid bound
   localparam int MAX_SIDE_DEF = 128;

   // Cell codes
   localparam int KIND_W = 2;
   localparam logic [KIND_W-1:0] KIND_OPEN     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_INFECTED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BLOCKED  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_RESERVED = 2'd3;

   // Register file
   localparam int SIDE_CFG_W = 8;
   localparam int DAYS_W     = 10;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_SIDE = 1'b0;
   localparam logic CSR_IDX_DAYS = 1'b1;

   // Job queue between loader and engine
   localparam int QUEUE_DEPTH = 2;

   // Address width of a store holding max_side squared entries
   function automatic int calc_addr_w(input int max_side);
      int depth;
      depth = max_side * max_side;
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

   // Width that holds a cell count up to max_side squared
   function automatic int calc_total_w(input int max_side);
      return $clog2(max_side * max_side + 1);
   endfunction

   // Width that holds a side up to max_side
   function automatic int calc_side_w(input int max_side);
      return $clog2(max_side + 1);
   endfunction

endpackage

`default_nettype wire

[rtl/core/gisc_front.sv]
// ============================================================================
// gisc_front
// Cell loader: takes cells in row-major order, folds the reserved code into
// blocked, writes the cell store and queues a job when the grid is complete.
// ============================================================================
`default_nettype none

module gisc_front
   import gisc_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [KIND_W-1:0]                       req_cell_kind,
   input  wire logic [calc_side_w(MAX_SIDE)-1:0]        side_eff,
   input  wire logic [calc_total_w(MAX_SIDE)-1:0]       total,
   input  wire logic [DAYS_W-1:0]                       days,
   input  wire logic                                    back_busy,
   input  wire logic                                    q_empty,
   output logic                                         cell_we,
   output logic [calc_addr_w(MAX_SIDE)-1:0]             cell_addr,
   output logic [KIND_W-1:0]                            cell_kind,
   output logic                                         job_push,
   output logic [calc_side_w(MAX_SIDE)+calc_total_w(MAX_SIDE)+DAYS_W-1:0] job_data
);

   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W      = calc_addr_w(MAX_SIDE);
   localparam int TOTAL_W     = calc_total_w(MAX_SIDE);
   localparam int WIDE_W      = TOTAL_W + 1;

   logic [TOTAL_W-1:0] load_index_ff;
   logic [TOTAL_W-1:0] load_index_in;
   logic               accept;
   logic               grid_done;
   logic [WIDE_W-1:0]  next_index;
   logic [DAYS_W-1:0]  rounds;

   // Hold off while a grid waits or the engine reads the store
   assign req_ready = q_empty && !back_busy;
   assign accept    = req_valid && req_ready;

   // Fold the reserved code into blocked
   assign cell_kind = (req_cell_kind == KIND_RESERVED) ? KIND_BLOCKED : req_cell_kind;
   assign cell_we   = accept;
   assign cell_addr = load_index_ff[ADDR_W-1:0];

   // Grid completes once the count reaches the current cell total
   assign next_index = WIDE_W'(load_index_ff) + WIDE_W'(1);
   assign grid_done  = next_index >= WIDE_W'(total);

   assign rounds   = (days > DAYS_W'(1)) ? (days - DAYS_W'(1)) : '0;
   assign job_push = accept && grid_done;
   assign job_data = {side_eff, total, rounds};

   // Advance or restart the load position
   always_comb begin
      load_index_in = load_index_ff;
      if (accept) begin
         if (grid_done) begin
            load_index_in = '0;
         end else begin
            load_index_in = next_index[TOTAL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_index_ff <= '0;
      end else begin
         load_index_ff <= load_index_in;
      end
   end

   // Load position stays inside the store
   a_index_in_store: assert property (@(posedge clock) disable iff (reset)
      int'(load_index_ff) < STORE_DEPTH)
      else $error("load index beyond cell store");

endmodule

`default_nettype wire

[rtl/core/gisc_queue.sv]
// ============================================================================
// gisc_queue
// Short job queue between the cell loader and the spreading engine.
// ============================================================================
`default_nettype none

module gisc_queue
   import gisc_pkg::*;
#(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic                   pop_valid,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   empty
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wptr_ff;
   logic [PTR_W-1:0]  wptr_in;
   logic [PTR_W-1:0]  rptr_ff;
   logic [PTR_W-1:0]  rptr_in;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              do_push;
   logic              do_pop;

   assign empty     = (count_ff == '0);
   assign pop_valid = !empty;
   assign pop_data  = slot_ff[rptr_ff];
   assign do_push   = push && (count_ff != CNT_W'(QUEUE_DEPTH));
   assign do_pop    = pop && !empty;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   // Loader never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != CNT_W'(QUEUE_DEPTH)))
      else $error("job pushed into full queue");

endmodule

`default_nettype wire

[rtl/core/gisc_back.sv]
// ============================================================================
// gisc_back
// Spreading engine: owns the cell store and two infection map banks, builds
// the initial map, runs the spreading rounds cell by cell and counts the
// infected cells into the result register.
// ============================================================================
`default_nettype none

module gisc_back
   import gisc_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    cell_we,
   input  wire logic [calc_addr_w(MAX_SIDE)-1:0]        cell_waddr,
   input  wire logic [KIND_W-1:0]                       cell_wkind,
   input  wire logic                                    job_valid,
   input  wire logic [calc_side_w(MAX_SIDE)+calc_total_w(MAX_SIDE)+DAYS_W-1:0] job_data,
   output logic                                         job_pop,
   output logic                                         busy,
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic [calc_total_w(MAX_SIDE)-1:0]            rsp_infected_count
);

   localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_W      = calc_addr_w(MAX_SIDE);
   localparam int TOTAL_W     = calc_total_w(MAX_SIDE);
   localparam int SIDE_W      = calc_side_w(MAX_SIDE);
   localparam int WIDE_W      = TOTAL_W + 1;

   // Engine states
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_INIT      = 4'd1;
   localparam logic [3:0] ST_PRIME     = 4'd2;
   localparam logic [3:0] ST_PRIME_CAP = 4'd3;
   localparam logic [3:0] ST_P0        = 4'd4;
   localparam logic [3:0] ST_P1        = 4'd5;
   localparam logic [3:0] ST_P2        = 4'd6;
   localparam logic [3:0] ST_COUNT     = 4'd7;
   localparam logic [3:0] ST_DONE      = 4'd8;

   // Stores
   logic [KIND_W-1:0] cell_mem [STORE_DEPTH];
   logic              map0_mem [STORE_DEPTH];
   logic              map1_mem [STORE_DEPTH];

   // Registered read data
   logic [KIND_W-1:0] cell_rd_ff;
   logic              a0_ff, a1_ff, b0_ff, b1_ff;

   // Control and scan state
   logic [3:0]         state_ff, state_in;
   logic [SIDE_W-1:0]  side_ff, side_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [DAYS_W-1:0]  rounds_ff, rounds_in;
   logic [TOTAL_W-1:0] t_ff, t_in;
   logic [SIDE_W-1:0]  r_ff, r_in;
   logic [SIDE_W-1:0]  c_ff, c_in;
   logic               bank_ff, bank_in;
   logic               changed_ff, changed_in;
   logic               cur_ff, cur_in;
   logic               prev_ff, prev_in;
   logic               nxt_ff, nxt_in;
   logic               pipe_v_ff, pipe_v_in;
   logic [ADDR_W-1:0]  pipe_addr_ff, pipe_addr_in;
   logic [TOTAL_W-1:0] cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0] rsp_count_ff, rsp_count_in;

   // Memory port controls
   logic              cell_re;
   logic [ADDR_W-1:0] cell_raddr;
   logic              a_re, b_re;
   logic [ADDR_W-1:0] a_addr, b_addr;
   logic              map_we, map_wbank, map_wbit;
   logic [ADDR_W-1:0] map_waddr;

   // Neighbor addressing and spread terms
   logic              rd_a, rd_b;
   logic [WIDE_W-1:0] sum_p1, sum_ps, diff_ms, side_x;
   logic [SIDE_W-1:0] side_m1;
   logic [TOTAL_W-1:0] total_m1;
   logic              r_first, r_last, c_first, c_last;
   logic              spread, new_bit, chg;

   assign rd_a = bank_ff ? a1_ff : a0_ff;
   assign rd_b = bank_ff ? b1_ff : b0_ff;

   assign side_x   = WIDE_W'(side_ff);
   assign sum_p1   = WIDE_W'(t_ff) + WIDE_W'(1);
   assign sum_ps   = WIDE_W'(t_ff) + side_x;
   assign diff_ms  = WIDE_W'(t_ff) - side_x;
   assign side_m1  = side_ff - SIDE_W'(1);
   assign total_m1 = total_ff - TOTAL_W'(1);

   assign r_first = (r_ff == '0);
   assign r_last  = (r_ff == side_m1);
   assign c_first = (c_ff == '0);
   assign c_last  = (c_ff == side_m1);

   // Pull form: open cell catches from any infected neighbor inside the grid
   assign spread  = (!r_first && rd_b) || (!r_last && rd_a) ||
                    (!c_first && prev_ff) || (!c_last && nxt_ff);
   assign new_bit = cur_ff || ((cell_rd_ff == KIND_OPEN) && spread);
   assign chg     = changed_ff || (new_bit != cur_ff);

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_infected_count = rsp_count_ff;

   // Sequence init pass, rounds and count pass
   always_comb begin
      state_in     = state_ff;
      side_in      = side_ff;
      total_in     = total_ff;
      rounds_in    = rounds_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      bank_in      = bank_ff;
      changed_in   = changed_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      nxt_in       = nxt_ff;
      pipe_v_in    = pipe_v_ff;
      pipe_addr_in = pipe_addr_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_count_in = rsp_count_ff;
      job_pop      = 1'b0;
      cell_re      = 1'b0;
      cell_raddr   = t_ff[ADDR_W-1:0];
      a_re         = 1'b0;
      a_addr       = t_ff[ADDR_W-1:0];
      b_re         = 1'b0;
      b_addr       = diff_ms[ADDR_W-1:0];
      map_we       = 1'b0;
      map_wbank    = bank_ff;
      map_waddr    = t_ff[ADDR_W-1:0];
      map_wbit     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               job_pop   = 1'b1;
               side_in   = job_data[TOTAL_W+DAYS_W +: SIDE_W];
               total_in  = job_data[DAYS_W +: TOTAL_W];
               rounds_in = job_data[DAYS_W-1:0];
               t_in      = '0;
               pipe_v_in = 1'b0;
               bank_in   = 1'b0;
               state_in  = ST_INIT;
            end
         end
         ST_INIT: begin
            // Stream cells in, write each infected flag in the cycle after its read
            pipe_v_in = 1'b0;
            if (t_ff != total_ff) begin
               cell_re      = 1'b1;
               pipe_v_in    = 1'b1;
               pipe_addr_in = t_ff[ADDR_W-1:0];
               t_in         = sum_p1[TOTAL_W-1:0];
            end
            if (pipe_v_ff) begin
               map_we    = 1'b1;
               map_wbank = bank_ff;
               map_waddr = pipe_addr_ff;
               map_wbit  = (cell_rd_ff == KIND_INFECTED);
            end
            if ((t_ff == total_ff) && !pipe_v_ff) begin
               t_in   = '0;
               cnt_in = '0;
               if (rounds_ff == '0) begin
                  state_in = ST_COUNT;
               end else begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            // Fetch the first cell of the current map
            a_re       = 1'b1;
            a_addr     = '0;
            t_in       = '0;
            r_in       = '0;
            c_in       = '0;
            changed_in = 1'b0;
            state_in   = ST_PRIME_CAP;
         end
         ST_PRIME_CAP: begin
            cur_in   = rd_a;
            prev_in  = 1'b0;
            state_in = ST_P0;
         end
         ST_P0: begin
            // Read right and upper neighbors and the cell kind
            a_re     = 1'b1;
            a_addr   = sum_p1[ADDR_W-1:0];
            b_re     = 1'b1;
            b_addr   = diff_ms[ADDR_W-1:0];
            cell_re  = 1'b1;
            state_in = ST_P1;
         end
         ST_P1: begin
            // Keep right neighbor, read lower neighbor
            nxt_in   = rd_a;
            a_re     = 1'b1;
            a_addr   = sum_ps[ADDR_W-1:0];
            state_in = ST_P2;
         end
         ST_P2: begin
            // Write the next map and slide the row window
            map_we     = 1'b1;
            map_wbank  = !bank_ff;
            map_waddr  = t_ff[ADDR_W-1:0];
            map_wbit   = new_bit;
            changed_in = chg;
            prev_in    = cur_ff;
            cur_in     = nxt_ff;
            if (t_ff == total_m1) begin
               bank_in   = !bank_ff;
               rounds_in = rounds_ff - DAYS_W'(1);
               t_in      = '0;
               if (!chg || (rounds_ff == DAYS_W'(1))) begin
                  cnt_in    = '0;
                  pipe_v_in = 1'b0;
                  state_in  = ST_COUNT;
               end else begin
                  state_in = ST_PRIME;
               end
            end else begin
               t_in = sum_p1[TOTAL_W-1:0];
               if (c_last) begin
                  c_in = '0;
                  r_in = r_ff + SIDE_W'(1);
               end else begin
                  c_in = c_ff + SIDE_W'(1);
               end
               state_in = ST_P0;
            end
         end
         ST_COUNT: begin
            // Stream the final map and add up infected cells
            pipe_v_in = 1'b0;
            if (t_ff != total_ff) begin
               a_re      = 1'b1;
               a_addr    = t_ff[ADDR_W-1:0];
               pipe_v_in = 1'b1;
               t_in      = sum_p1[TOTAL_W-1:0];
            end
            if (pipe_v_ff) begin
               cnt_in = cnt_ff + TOTAL_W'(rd_a);
            end
            if ((t_ff == total_ff) && !pipe_v_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // Hand the count to the result register once it is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         pipe_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         pipe_v_ff    <= pipe_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      side_ff      <= side_in;
      total_ff     <= total_in;
      rounds_ff    <= rounds_in;
      t_ff         <= t_in;
      r_ff         <= r_in;
      c_ff         <= c_in;
      changed_ff   <= changed_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      nxt_ff       <= nxt_in;
      pipe_addr_ff <= pipe_addr_in;
      cnt_ff       <= cnt_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Cell store: loader writes, engine reads
   always_ff @(posedge clock) begin
      if (cell_we) begin
         cell_mem[cell_waddr] <= cell_wkind;
      end
      if (cell_re) begin
         cell_rd_ff <= cell_mem[cell_raddr];
      end
   end

   // Map bank 0
   always_ff @(posedge clock) begin
      if (map_we && !map_wbank) begin
         map0_mem[map_waddr] <= map_wbit;
      end
      if (a_re) begin
         a0_ff <= map0_mem[a_addr];
      end
      if (b_re) begin
         b0_ff <= map0_mem[b_addr];
      end
   end

   // Map bank 1
   always_ff @(posedge clock) begin
      if (map_we && map_wbank) begin
         map1_mem[map_waddr] <= map_wbit;
      end
      if (a_re) begin
         a1_ff <= map1_mem[a_addr];
      end
      if (b_re) begin
         b1_ff <= map1_mem[b_addr];
      end
   end

   // Cell update only after both neighbor reads
   a_p2_after_p1: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_P2) |-> ($past(state_ff) == ST_P1))
      else $error("cell update without neighbor reads");

   // Count never exceeds the cells of the grid
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (cnt_ff <= total_ff))
      else $error("infected count above grid size");

endmodule

`default_nettype wire

[rtl/core/grid_infection_spread_count_core.sv]
// ============================================================================
// grid_infection_spread_count_core
// Loads a square grid one cell per transfer, spreads infection over 4-neighbor
// cells for days minus one rounds and returns the infected cell count.
// ============================================================================
// Usage:
//   Write side (address 0) and days (address 4) over the register port,
//   then send side*side cells in row-major order on the req_ channel, one
//   transfer per cycle (0 open, 1 infected, 2 or 3 blocked).
//   The transfer that completes the grid starts the engine; req_ready stays
//   low until the engine finishes. The engine builds the first map, then
//   runs the rounds (days minus one, fewer once the map stops changing),
//   walking the map banks a single cell per step, and then counts the map.
//   One count comes out on the rsp_ channel per grid, from a result
//   register: the next grid loads while a count waits, but its engine run
//   ends only once the receiver takes the previous count.
//   Reset sets side and days to 1, clears the load position, queue and
//   engine; the stores are not cleared and each grid rewrites what it uses.
// ============================================================================
`default_nettype none

module grid_infection_spread_count_core
   import gisc_pkg::*;
#(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Cell input
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [KIND_W-1:0]                req_cell_kind,
   // Count output
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [calc_total_w(MAX_SIDE)-1:0]     rsp_infected_count,
   // Register port
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [CSR_ADDR_W-1:0]            paddr,
   input  wire logic [CSR_DATA_W-1:0]            pwdata,
   output logic [CSR_DATA_W-1:0]                 prdata,
   output logic                                  pready
);

   localparam int ADDR_W  = calc_addr_w(MAX_SIDE);
   localparam int TOTAL_W = calc_total_w(MAX_SIDE);
   localparam int SIDE_W  = calc_side_w(MAX_SIDE);
   localparam int JOB_W   = SIDE_W + TOTAL_W + DAYS_W;

   logic [SIDE_CFG_W-1:0] side_ff, side_in;
   logic [DAYS_W-1:0]     days_ff, days_in;
   logic [SIDE_W-1:0]     side_eff_ff, side_eff_in;
   logic [TOTAL_W-1:0]    total_ff, total_in;
   logic [SIDE_CFG_W-1:0] wr_side;
   logic [2*SIDE_W-1:0]   wr_square;
   logic                  csr_write;

   logic                  back_busy;
   logic                  q_empty;
   logic                  cell_we;
   logic [ADDR_W-1:0]     cell_addr;
   logic [KIND_W-1:0]     cell_kind;
   logic                  job_push;
   logic [JOB_W-1:0]      job_data;
   logic                  job_valid;
   logic [JOB_W-1:0]      job_head;
   logic                  job_pop;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign wr_side   = pwdata[SIDE_CFG_W-1:0];

   // Clamp the written side and square it at write time
   always_comb begin
      if (wr_side == '0) begin
         side_eff_in = SIDE_W'(1);
      end else if (int'(wr_side) > MAX_SIDE) begin
         side_eff_in = SIDE_W'(MAX_SIDE);
      end else begin
         side_eff_in = SIDE_W'(wr_side);
      end
   end

   assign wr_square = side_eff_in * side_eff_in;

   // Register writes
   always_comb begin
      side_in  = side_ff;
      days_in  = days_ff;
      total_in = total_ff;
      if (csr_write) begin
         case (paddr[2])
            CSR_IDX_SIDE: begin
               side_in  = wr_side;
               total_in = TOTAL_W'(wr_square);
            end
            CSR_IDX_DAYS: begin
               days_in = pwdata[DAYS_W-1:0];
            end
            default: begin
               days_in = days_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff     <= SIDE_CFG_W'(1);
         days_ff     <= DAYS_W'(1);
         side_eff_ff <= SIDE_W'(1);
         total_ff    <= TOTAL_W'(1);
      end else begin
         side_ff  <= side_in;
         days_ff  <= days_in;
         total_ff <= total_in;
         if (csr_write && (paddr[2] == CSR_IDX_SIDE)) begin
            side_eff_ff <= side_eff_in;
         end
      end
   end

   // Register reads
   always_comb begin
      case (paddr[2])
         CSR_IDX_SIDE: prdata = CSR_DATA_W'(side_ff);
         CSR_IDX_DAYS: prdata = CSR_DATA_W'(days_ff);
         default:      prdata = '0;
      endcase
   end

   gisc_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_cell_kind (req_cell_kind),
      .side_eff      (side_eff_ff),
      .total         (total_ff),
      .days          (days_ff),
      .back_busy     (back_busy),
      .q_empty       (q_empty),
      .cell_we       (cell_we),
      .cell_addr     (cell_addr),
      .cell_kind     (cell_kind),
      .job_push      (job_push),
      .job_data      (job_data)
   );

   gisc_queue #(
      .DATA_W (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_data),
      .pop       (job_pop),
      .pop_valid (job_valid),
      .pop_data  (job_head),
      .empty     (q_empty)
   );

   gisc_back #(
      .MAX_SIDE (MAX_SIDE)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cell_we            (cell_we),
      .cell_waddr         (cell_addr),
      .cell_wkind         (cell_kind),
      .job_valid          (job_valid),
      .job_data           (job_head),
      .job_pop            (job_pop),
      .busy               (back_busy),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_infected_count (rsp_infected_count)
   );

endmodule

`default_nettype wire

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Grid infection spread counter testbench
// Loads square grids cell by cell through the request channel, sets grid size
// and day count over the register port, and checks every returned infected
// count against a behavioral predictor of the spreading rounds or a count
// given in the table. A short table of hand-picked grids runs first, then a
// saturated-side load cut short by a side change, then random grids under
// several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gisc_pkg::*;

   localparam int GRID_MAX      = MAX_SIDE_DEF;
   localparam int CELLS_MAX     = GRID_MAX * GRID_MAX;
   localparam int COUNT_W       = calc_total_w(MAX_SIDE_DEF);
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 64;
   localparam int CYCLE_LIMIT   = 10_000_000;
   localparam int RANDOM_CELLS  = 1800;
   localparam int PHASES        = 4;
   localparam int PARTIAL_CELLS = 40;

   localparam logic [CSR_ADDR_W-1:0] ADDR_SIDE = {CSR_IDX_SIDE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_DAYS = {CSR_IDX_DAYS, 2'b00};

   typedef enum logic [1:0] {STEP_CELL, STEP_SIDE, STEP_DAYS} step_kind_type;

   typedef struct packed {
      step_kind_type      kind;
      logic [9:0]         value;
      logic               has_count;
      logic [COUNT_W-1:0] count;
   } plan_row_type;

   localparam int PLAN_ROWS = 32;
   localparam plan_row_type PLAN [PLAN_ROWS] = '{
      // single-cell grids straight out of reset
      '{STEP_CELL, 10'(KIND_OPEN),     1'b1, 15'd0},
      '{STEP_CELL, 10'(KIND_INFECTED), 1'b1, 15'd1},
      '{STEP_CELL, 10'(KIND_BLOCKED),  1'b1, 15'd0},
      '{STEP_CELL, 10'(KIND_RESERVED), 1'b1, 15'd0},
      // side zero acts as one
      '{STEP_SIDE, 10'd0,              1'b0, 15'd0},
      '{STEP_DAYS, 10'd0,              1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_INFECTED), 1'b1, 15'd1},
      // 2x2, full day count, blocked corner
      '{STEP_SIDE, 10'd2,              1'b0, 15'd0},
      '{STEP_DAYS, 10'd1023,           1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_INFECTED), 1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_BLOCKED),  1'b1, 15'd3},
      // one day gives no spreading
      '{STEP_DAYS, 10'd1,              1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_INFECTED), 1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b1, 15'd1},
      // shrink the side in the middle of a 3x3 load
      '{STEP_SIDE, 10'd3,              1'b0, 15'd0},
      '{STEP_DAYS, 10'd2,              1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_INFECTED), 1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_SIDE, 10'd2,              1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      // two rounds around a blocked corner
      '{STEP_DAYS, 10'd3,              1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_BLOCKED),  1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_OPEN),     1'b0, 15'd0},
      '{STEP_CELL, 10'(KIND_INFECTED), 1'b0, 15'd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [KIND_W-1:0]     req_cell_kind;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [COUNT_W-1:0]    rsp_infected_count;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   grid_infection_spread_count_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cell_kind      (req_cell_kind),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_infected_count (rsp_infected_count),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // Predictor state: register copies, cell store, load position, maps
   bit [SIDE_CFG_W-1:0] cfg_side = SIDE_CFG_W'(1);
   bit [DAYS_W-1:0]     cfg_days = DAYS_W'(1);
   bit [KIND_W-1:0]     grid_cells [CELLS_MAX];
   bit                  now_map    [CELLS_MAX];
   bit                  next_map   [CELLS_MAX];
   int unsigned         load_pos = 0;

   logic [COUNT_W-1:0]  pending_counts [$];
   int unsigned         mismatch_total = 0;
   int unsigned         sender_idle_pct = 0;
   int unsigned         rsp_stall_pct = 0;
   int unsigned         cycle_count = 0;

   always #1 clock = ~clock;

   // Side as the block uses it: zero acts as one, large values saturate
   function automatic int unsigned grid_side();
      if (cfg_side == 0) return 1;
      if (cfg_side > GRID_MAX) return GRID_MAX;
      return 32'(cfg_side);
   endfunction

   // Mark an open cell in the next map; report whether it is newly infected
   function automatic bit infect_open(input int unsigned idx);
      if (grid_cells[idx] == KIND_OPEN && !next_map[idx]) begin
         next_map[idx] = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Run the spreading rounds over an s by s grid and count infected cells
   function automatic logic [COUNT_W-1:0] count_infected(input int unsigned s);
      int unsigned total, rounds, k, r, c, idx, tally;
      bit changed;
      total  = s * s;
      rounds = (cfg_days > 1) ? cfg_days - 1 : 0;
      tally  = 0;
      for (k = 0; k < total; k++) now_map[k] = (grid_cells[k] == KIND_INFECTED);
      for (k = 0; k < rounds; k++) begin
         changed = 1'b0;
         for (idx = 0; idx < total; idx++) next_map[idx] = now_map[idx];
         for (r = 0; r < s; r++) begin
            for (c = 0; c < s; c++) begin
               idx = r * s + c;
               if (now_map[idx]) begin
                  if (r > 0)     changed |= infect_open(idx - s);
                  if (r + 1 < s) changed |= infect_open(idx + s);
                  if (c > 0)     changed |= infect_open(idx - 1);
                  if (c + 1 < s) changed |= infect_open(idx + 1);
               end
            end
         end
         for (idx = 0; idx < total; idx++) now_map[idx] = next_map[idx];
         // stop early once the map is stable
         if (!changed) break;
      end
      for (k = 0; k < total; k++) tally += now_map[k];
      return tally[COUNT_W-1:0];
   endfunction

   // Store one cell; on grid completion return 1 with the infected count
   function automatic bit load_cell(input logic [KIND_W-1:0] kind,
                                    output logic [COUNT_W-1:0] tally);
      int unsigned s;
      logic [KIND_W-1:0] stored;
      s      = grid_side();
      stored = (kind == KIND_RESERVED) ? KIND_BLOCKED : kind;
      tally  = '0;
      if (load_pos < CELLS_MAX) grid_cells[load_pos] = stored;
      load_pos = (load_pos + 1) & 32'h7FFF;
      if (load_pos >= s * s) begin
         tally    = count_infected(s);
         load_pos = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Send one cell with optional idle gap; queue the count if a grid completes
   task automatic send_cell(input logic [KIND_W-1:0] kind, input bit has_typed,
                            input logic [COUNT_W-1:0] typed_count, output bit done);
      logic [COUNT_W-1:0] predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cell_kind <= kind;
      do @(posedge clock); while (!req_ready);
      done = load_cell(kind, predicted);
      if (done) pending_counts.push_back(has_typed ? typed_count : predicted);
   endtask

   // Drop valid, wait for every outstanding count, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write: setup phase, access phase, then an idle phase
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input int unsigned data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == ADDR_SIDE) cfg_side = data[SIDE_CFG_W-1:0];
      else cfg_days = data[DAYS_W-1:0];
      @(posedge clock);
   endtask

   function automatic int unsigned pick_side();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 5) return 0;
      if (roll < 85) return $urandom_range(1, 8);
      return $urandom_range(9, 16);
   endfunction

   function automatic int unsigned pick_days();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 10) return 0;
      if (roll < 20) return 1;
      if (roll < 35) return 2;
      if (roll < 45) return 1023;
      if (roll < 70) return $urandom_range(3, 20);
      return $urandom_range(0, 1023);
   endfunction

   function automatic logic [KIND_W-1:0] pick_kind(input int unsigned inf_pct,
                                                   input int unsigned blk_pct);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < inf_pct) return KIND_INFECTED;
      if (roll < inf_pct + blk_pct)
         return ($urandom_range(9) == 0) ? KIND_RESERVED : KIND_BLOCKED;
      return KIND_OPEN;
   endfunction

   // One random grid, with optional new settings and a side change mid-load
   task automatic random_grid(output int unsigned sent);
      int unsigned inf_pct, blk_pct, split, eff;
      bit done;
      if ($urandom_range(99) < 60) begin
         wait_idle();
         if ($urandom_range(1)) csr_write(ADDR_SIDE, pick_side());
         if ($urandom_range(1)) csr_write(ADDR_DAYS, pick_days());
      end
      eff     = grid_side();
      split   = (eff > 1 && $urandom_range(99) < 8) ? $urandom_range(1, eff * eff - 1) : 0;
      inf_pct = $urandom_range(1, 20);
      blk_pct = $urandom_range(0, 40);
      sent    = 0;
      done    = 1'b0;
      while (!done) begin
         if (split != 0 && sent == split) begin
            wait_idle();
            csr_write(ADDR_SIDE, pick_side());
         end
         send_cell(pick_kind(inf_pct, blk_pct), 1'b0, '0, done);
         sent++;
      end
   endtask

   // Check each count transfer against the oldest prediction; randomize ready
   always @(posedge clock) begin : count_check
      logic [COUNT_W-1:0] want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            $display("%0t: count %0d arrived with none expected", $time, rsp_infected_count);
            mismatch_total++;
         end else begin
            want = pending_counts.pop_front();
            if (want !== rsp_infected_count) begin
               $display("%0t: infected_count expected %0d actual %0d",
                        $time, want, rsp_infected_count);
               mismatch_total++;
            end
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int unsigned i, phase, phase_cells, sent;
      bit done;
      clock         = 1'b0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cell_kind = KIND_OPEN;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table
      for (i = 0; i < PLAN_ROWS; i++) begin
         case (PLAN[i].kind)
            STEP_SIDE: begin
               wait_idle();
               csr_write(ADDR_SIDE, 32'(PLAN[i].value));
            end
            STEP_DAYS: begin
               wait_idle();
               csr_write(ADDR_DAYS, 32'(PLAN[i].value));
            end
            default: begin
               send_cell(PLAN[i].value[KIND_W-1:0], PLAN[i].has_count, PLAN[i].count,
                         done);
            end
         endcase
      end

      // Saturated side: load part of a large grid, then shrink so it completes
      wait_idle();
      csr_write(ADDR_SIDE, 255);
      csr_write(ADDR_DAYS, 0);
      for (i = 0; i < PARTIAL_CELLS; i++)
         send_cell(KIND_INFECTED, 1'b0, '0, done);
      wait_idle();
      csr_write(ADDR_SIDE, 5);
      csr_write(ADDR_DAYS, 2);
      do send_cell(pick_kind(5, 30), 1'b0, '0, done); while (!done);

      // Random grids under each idling pattern
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 79; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 79; end
            default: begin sender_idle_pct = 9; rsp_stall_pct = 9; end
         endcase
         phase_cells = 0;
         while (phase_cells < RANDOM_CELLS / PHASES) begin
            random_grid(sent);
            phase_cells += sent;
         end
      end

      // Drain and give stray results a chance to show up
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_total == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
